/* rtl/sar_pkg.sv */
package sar_pkg;

    // fixed field widths
    localparam int ANGLE_W = 16;
    localparam int SPEED_W = 16;
    localparam int OP_W    = 3;
    localparam int STEP_W  = 8;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 3'd0,
        OP_GO     = 3'd1,
        OP_STOP   = 3'd2,
        OP_SET    = 3'd3,
        OP_STATUS = 3'd4
    } t_sar_op;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_COMMIT
    } t_sar_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic commit;
    } t_sar_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_is_go;
        logic div_last;
        logic out_free;
    } t_sar_stat;

endpackage

/* rtl/sar_ctrl.sv */
module sar_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sar_pkg::t_sar_stat  i_stat,
    output sar_pkg::t_sar_cmd   o_cmd
);
    import sar_pkg::*;

    t_sar_state r_state;
    t_sar_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.in_is_go ? ST_DIV : ST_COMMIT;
                end
            end
            ST_DIV: begin
                if (i_stat.div_last) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.div_step = 1'b0;
        o_cmd.commit   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_COMMIT: begin
                o_cmd.commit = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/sar_dp.sv */
module sar_dp #(
    parameter int TICKS_PER_SECOND = 1000
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sar_pkg::t_sar_cmd                   i_cmd,
    output sar_pkg::t_sar_stat                  o_stat,
    input  logic                                i_cfg_valid,
    input  logic [sar_pkg::STEP_W-1:0]          i_step_size,
    input  logic [sar_pkg::OP_W-1:0]            i_operation,
    input  logic signed [sar_pkg::ANGLE_W-1:0]  i_angle_value,
    input  logic [sar_pkg::SPEED_W-1:0]         i_speed,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_drive_valid,
    output logic signed [sar_pkg::ANGLE_W-1:0]  o_drive_angle,
    output logic                                o_reached_event,
    output logic signed [sar_pkg::ANGLE_W-1:0]  o_reached_angle,
    output logic                                o_busy_res,
    output logic                                o_reached_flag
);
    import sar_pkg::*;

    localparam int QW = $clog2(TICKS_PER_SECOND + 1);
    localparam int CW = $clog2(QW + 1);

    // request latched at acceptance
    logic [OP_W-1:0]           r_op;
    logic signed [ANGLE_W-1:0] r_ang;
    logic [SPEED_W-1:0]        r_div;

    // divider
    logic [SPEED_W-1:0] r_rem;
    logic [QW-1:0]      r_quo;
    logic [CW-1:0]      r_cnt;
    logic [SPEED_W:0]   trial;
    logic               q_bit;
    logic [QW:0]        quo_shift;

    // block state
    logic [STEP_W-1:0]         r_step;
    logic signed [ANGLE_W-1:0] r_cur;
    logic signed [ANGLE_W-1:0] r_tgt;
    logic [QW-1:0]             r_interval;
    logic [QW-1:0]             r_tick;
    logic                      r_running;
    logic                      r_sticky;

    logic signed [ANGLE_W-1:0] n_cur;
    logic signed [ANGLE_W-1:0] n_tgt;
    logic [QW-1:0]             n_interval;
    logic [QW-1:0]             n_tick;
    logic                      n_running;
    logic                      n_sticky;
    logic                      n_drove;
    logic                      n_reached;
    logic                      n_flag;

    // result register
    logic                      r_out_valid;
    logic                      r_drive_valid;
    logic signed [ANGLE_W-1:0] r_drive_angle;
    logic                      r_reached_event;
    logic signed [ANGLE_W-1:0] r_reached_angle;
    logic                      r_busy_res;
    logic                      r_reached_flag;

    // status to controller
    assign o_stat.in_is_go = (t_sar_op'(i_operation) == OP_GO);
    assign o_stat.div_last = (r_cnt == '0);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_W'(1);
        end else if (i_cfg_valid) begin
            r_step <= i_step_size;
        end
    end

    // one restoring division step, one quotient bit
    always_comb begin
        trial     = {r_rem, r_quo[QW-1]};
        q_bit     = (trial >= {1'b0, r_div});
        quo_shift = {r_quo, q_bit};
    end

    // request latch and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_ang <= i_angle_value;
            r_div <= (i_speed == '0) ? SPEED_W'(1) : i_speed;
            r_rem <= '0;
            r_quo <= QW'(TICKS_PER_SECOND);
            r_cnt <= CW'(QW - 1);
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? SPEED_W'(trial - {1'b0, r_div}) : trial[SPEED_W-1:0];
            r_quo <= quo_shift[QW-1:0];
            r_cnt <= r_cnt - CW'(1);
        end
    end

    // operation effect on the state
    always_comb begin
        logic [QW-1:0]           tick_inc;
        logic signed [ANGLE_W:0] delta;
        logic [ANGLE_W:0]        mag;
        logic signed [ANGLE_W:0] step_ext;

        n_cur      = r_cur;
        n_tgt      = r_tgt;
        n_interval = r_interval;
        n_tick     = r_tick;
        n_running  = r_running;
        n_sticky   = r_sticky;
        n_drove    = 1'b0;
        n_reached  = 1'b0;
        n_flag     = 1'b0;

        tick_inc = r_tick + QW'(1);
        delta    = (ANGLE_W+1)'(r_tgt) - (ANGLE_W+1)'(r_cur);
        mag      = delta[ANGLE_W] ? (ANGLE_W+1)'(-delta) : delta;
        step_ext = signed'({{(ANGLE_W+1-STEP_W){1'b0}}, r_step});

        unique case (t_sar_op'(r_op))
            OP_TICK: begin
                if (r_running) begin
                    if (tick_inc >= r_interval) begin
                        n_tick = '0;
                        if (delta == '0) begin
                            n_running = 1'b0;
                            n_sticky  = 1'b1;
                            n_reached = 1'b1;
                        end else begin
                            n_drove = 1'b1;
                            if (mag < (ANGLE_W+1)'(r_step)) begin
                                n_cur = r_tgt;
                            end else if (delta[ANGLE_W]) begin
                                n_cur = ANGLE_W'((ANGLE_W+1)'(r_cur) - step_ext);
                            end else begin
                                n_cur = ANGLE_W'((ANGLE_W+1)'(r_cur) + step_ext);
                            end
                        end
                    end else begin
                        n_tick = tick_inc;
                    end
                end
            end
            OP_GO: begin
                n_sticky   = 1'b0;
                n_tgt      = r_ang;
                n_interval = (r_quo == '0) ? QW'(1) : r_quo;
                n_tick     = '0;
                n_running  = 1'b1;
            end
            OP_STOP: begin
                n_running = 1'b0;
            end
            OP_SET: begin
                n_cur   = r_ang;
                n_drove = 1'b1;
            end
            OP_STATUS: begin
                n_flag   = r_sticky;
                n_sticky = 1'b0;
            end
            default: begin
                n_flag = 1'b0;
            end
        endcase
    end

    // state update on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur      <= '0;
            r_tgt      <= '0;
            r_interval <= QW'(TICKS_PER_SECOND);
            r_tick     <= '0;
            r_running  <= 1'b0;
            r_sticky   <= 1'b0;
        end else if (i_cmd.commit) begin
            r_cur      <= n_cur;
            r_tgt      <= n_tgt;
            r_interval <= n_interval;
            r_tick     <= n_tick;
            r_running  <= n_running;
            r_sticky   <= n_sticky;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_drive_valid   <= n_drove;
            r_drive_angle   <= n_cur;
            r_reached_event <= n_reached;
            r_reached_angle <= n_reached ? r_tgt : '0;
            r_busy_res      <= n_running;
            r_reached_flag  <= n_flag;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_drive_valid   = r_drive_valid;
    assign o_drive_angle   = r_drive_angle;
    assign o_reached_event = r_reached_event;
    assign o_reached_angle = r_reached_angle;
    assign o_busy_res      = r_busy_res;
    assign o_reached_flag  = r_reached_flag;

    // interval never collapses to zero
    a_interval_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_interval != '0)
        else $error("interval length is zero");

    // tick count stays below the interval while running
    a_tick_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> (r_tick < r_interval))
        else $error("tick count reached interval without expiry");

    // an expiry either drives or reports reached, never both
    a_drive_xor_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_drive_valid && r_reached_event))
        else $error("drive and reached event in one result");

    // a reached event stops the timer
    a_reached_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_reached_event) |-> !r_busy_res)
        else $error("timer still running after reached event");

endmodule

/* rtl/servo_angle_ramp_core.sv */
// channel   valid / ready                payload
// ------    -------------------------    ----------------------------------------------
// in        i_in_valid / o_in_ready      i_operation, i_angle_value, i_speed
// out       o_out_valid / i_out_ready    o_drive_valid, o_drive_angle, o_reached_event,
//                                        o_reached_angle, o_busy_res, o_reached_flag
// cfg       i_cfg_valid / o_cfg_ready    i_step_size
//
// one request at a time: tick, stop, set angle and read status go straight from idle to commit;
// go to target first runs the divider for a W-bit quotient, W = bits of TICKS_PER_SECOND (10 at 1000),
// and the divider produces one quotient bit per cycle
// a finished result waits in the output register while the next request is taken
// a stalled output holds the commit of the following request until the slot frees
// reset is synchronous, active low; no clearing pass is needed
module servo_angle_ramp_core #(
    parameter int TICKS_PER_SECOND = 1000
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sar_pkg::STEP_W-1:0]          i_step_size,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [sar_pkg::OP_W-1:0]            i_operation,
    input  logic signed [sar_pkg::ANGLE_W-1:0]  i_angle_value,
    input  logic [sar_pkg::SPEED_W-1:0]         i_speed,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_drive_valid,
    output logic signed [sar_pkg::ANGLE_W-1:0]  o_drive_angle,
    output logic                                o_reached_event,
    output logic signed [sar_pkg::ANGLE_W-1:0]  o_reached_angle,
    output logic                                o_busy_res,
    output logic                                o_reached_flag
);
    import sar_pkg::*;

    t_sar_cmd  cmd;
    t_sar_stat stat;

    // step size register always writable
    assign o_cfg_ready = 1'b1;

    // sequencer
    sar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath
    sar_dp #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_valid     (i_cfg_valid),
        .i_step_size     (i_step_size),
        .i_operation     (i_operation),
        .i_angle_value   (i_angle_value),
        .i_speed         (i_speed),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_drive_valid   (o_drive_valid),
        .o_drive_angle   (o_drive_angle),
        .o_reached_event (o_reached_event),
        .o_reached_angle (o_reached_angle),
        .o_busy_res      (o_busy_res),
        .o_reached_flag  (o_reached_flag)
    );

endmodule

/* bench/servo_angle_ramp_checker.sv */
`timescale 1ns / 100ps

module servo_angle_ramp_checker #(
    parameter int TICKS_PER_SECOND = 1000
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [sar_pkg::STEP_W-1:0]          i_step_size,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [sar_pkg::OP_W-1:0]            i_operation,
    input  logic signed [sar_pkg::ANGLE_W-1:0]  i_angle_value,
    input  logic [sar_pkg::SPEED_W-1:0]         i_speed,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic                                i_drive_valid,
    input  logic signed [sar_pkg::ANGLE_W-1:0]  i_drive_angle,
    input  logic                                i_reached_event,
    input  logic signed [sar_pkg::ANGLE_W-1:0]  i_reached_angle,
    input  logic                                i_busy_res,
    input  logic                                i_reached_flag,
    output int                                  o_errors,
    output int                                  o_pending,
    output int                                  o_results,
    output int                                  o_reached
);
    import sar_pkg::*;

    typedef struct packed {
        logic                       drive_valid;
        logic signed [ANGLE_W-1:0]  drive_angle;
        logic                       reached_event;
        logic signed [ANGLE_W-1:0]  reached_angle;
        logic                       busy;
        logic                       flag;
    } t_ramp_result;

    // mirror of the ramp state
    logic signed [ANGLE_W-1:0]  pos_angle;
    logic signed [ANGLE_W-1:0]  goal_angle;
    int                         interval_ticks;
    int                         tick_cnt;
    logic                       timer_on;
    logic                       reached_latch;
    logic [STEP_W-1:0]          step_q;

    t_ramp_result               angle_results_q[$];
    t_ramp_result               want;
    int                         err_cnt;
    int                         result_cnt;
    int                         reached_cnt;

    // one control interval: step toward the goal or report arrival
    function automatic void ramp_interval(ref t_ramp_result r);
        int gap;
        int mag;
        int step;
        gap  = int'(goal_angle) - int'(pos_angle);
        mag  = (gap < 0) ? -gap : gap;
        step = int'(step_q);
        if (gap == 0) begin
            timer_on        = 1'b0;
            reached_latch   = 1'b1;
            r.reached_event = 1'b1;
            r.reached_angle = goal_angle;
        end else begin
            if (mag < step)
                pos_angle = goal_angle;
            else if (gap > 0)
                pos_angle = ANGLE_W'(int'(pos_angle) + step);
            else
                pos_angle = ANGLE_W'(int'(pos_angle) - step);
            r.drive_valid = 1'b1;
        end
    endfunction

    // apply one request to the mirror and give the result it should produce
    function automatic t_ramp_result ramp_predict(logic [OP_W-1:0] op,
                                                  logic signed [ANGLE_W-1:0] ang,
                                                  logic [SPEED_W-1:0] spd);
        t_ramp_result r;
        int rate;
        r = '0;
        case (op)
            OP_TICK: begin
                if (timer_on) begin
                    tick_cnt++;
                    if (tick_cnt >= interval_ticks) begin
                        tick_cnt = 0;
                        ramp_interval(r);
                    end
                end
            end
            OP_GO: begin
                reached_latch  = 1'b0;
                goal_angle     = ang;
                rate           = (spd == '0) ? 1 : int'(spd);
                interval_ticks = TICKS_PER_SECOND / rate;
                if (interval_ticks < 1)
                    interval_ticks = 1;
                tick_cnt = 0;
                timer_on = 1'b1;
            end
            OP_STOP: begin
                timer_on = 1'b0;
            end
            OP_SET: begin
                pos_angle     = ang;
                r.drive_valid = 1'b1;
            end
            OP_STATUS: begin
                r.flag        = reached_latch;
                reached_latch = 1'b0;
            end
            default: ;
        endcase
        r.drive_angle = pos_angle;
        r.busy        = timer_on;
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] exp_val,
                               input logic signed [31:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            err_cnt++;
        end
    endtask

    // watch the three channels and score each result against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pos_angle      = '0;
            goal_angle     = '0;
            interval_ticks = TICKS_PER_SECOND;
            tick_cnt       = 0;
            timer_on       = 1'b0;
            reached_latch  = 1'b0;
            step_q         = STEP_W'(1);
            angle_results_q.delete();
            err_cnt        = 0;
            result_cnt     = 0;
            reached_cnt    = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                step_q = i_step_size;
            if (i_in_valid && i_in_ready)
                angle_results_q.push_back(ramp_predict(i_operation, i_angle_value, i_speed));
            if (i_out_valid && i_out_ready) begin
                result_cnt++;
                if (i_reached_event === 1'b1)
                    reached_cnt++;
                if (angle_results_q.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    err_cnt++;
                end else begin
                    want = angle_results_q.pop_front();
                    check_field("drive_valid", want.drive_valid, i_drive_valid);
                    check_field("drive_angle", want.drive_angle, i_drive_angle);
                    check_field("reached_event", want.reached_event, i_reached_event);
                    check_field("reached_angle", want.reached_angle, i_reached_angle);
                    check_field("busy_res", want.busy, i_busy_res);
                    check_field("reached_flag", want.flag, i_reached_flag);
                end
            end
        end
        o_errors  <= err_cnt;
        o_pending <= angle_results_q.size();
        o_results <= result_cnt;
        o_reached <= reached_cnt;
    end

endmodule

/* bench/servo_angle_ramp_core_tb.sv */
`timescale 1ns / 100ps

module servo_angle_ramp_core_tb;
    import sar_pkg::*;

    localparam int              TICK_RATE   = 1000;
    localparam int              HOLD_CYCLES = 300;
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_cfg_valid   = 1'b0;
    logic [STEP_W-1:0]          i_step_size   = '0;
    logic                       i_in_valid    = 1'b0;
    logic [OP_W-1:0]            i_operation   = '0;
    logic signed [ANGLE_W-1:0]  i_angle_value = '0;
    logic [SPEED_W-1:0]         i_speed       = '0;
    logic                       i_out_ready   = 1'b0;
    logic                       o_cfg_ready;
    logic                       o_in_ready;
    logic                       o_out_valid;
    logic                       o_drive_valid;
    logic signed [ANGLE_W-1:0]  o_drive_angle;
    logic                       o_reached_event;
    logic signed [ANGLE_W-1:0]  o_reached_angle;
    logic                       o_busy_res;
    logic                       o_reached_flag;

    int                         fail_cnt;
    int                         pending_cnt;
    int                         result_cnt;
    int                         reached_cnt;
    int                         sent_cnt      = 0;
    int                         send_idle     = 0;
    int                         recv_idle     = 30;
    int                         hold_cnt      = 0;
    logic                       long_hold     = 1'b0;
    logic [STEP_W-1:0]          cur_step      = STEP_W'(1);

    servo_angle_ramp_core #(
        .TICKS_PER_SECOND(TICK_RATE)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_step_size     (i_step_size),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_angle_value   (i_angle_value),
        .i_speed         (i_speed),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_drive_valid   (o_drive_valid),
        .o_drive_angle   (o_drive_angle),
        .o_reached_event (o_reached_event),
        .o_reached_angle (o_reached_angle),
        .o_busy_res      (o_busy_res),
        .o_reached_flag  (o_reached_flag)
    );

    servo_angle_ramp_checker #(
        .TICKS_PER_SECOND(TICK_RATE)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_step_size     (i_step_size),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_angle_value   (i_angle_value),
        .i_speed         (i_speed),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_drive_valid   (o_drive_valid),
        .i_drive_angle   (o_drive_angle),
        .i_reached_event (o_reached_event),
        .i_reached_angle (o_reached_angle),
        .i_busy_res      (o_busy_res),
        .i_reached_flag  (o_reached_flag),
        .o_errors        (fail_cnt),
        .o_pending       (pending_cnt),
        .o_results       (result_cnt),
        .o_reached       (reached_cnt)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random back-pressure, plus one long hold when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_cnt    <= 0;
        end else if (long_hold && hold_cnt < HOLD_CYCLES) begin
            i_out_ready <= 1'b0;
            hold_cnt    <= hold_cnt + 1;
        end else begin
            if (!long_hold)
                hold_cnt <= 0;
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // offer one request and wait for it to be taken
    task automatic send_req(input logic [OP_W-1:0] op, input logic signed [ANGLE_W-1:0] ang,
                            input logic [SPEED_W-1:0] spd);
        if ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_angle_value <= ang;
        i_speed       <= spd;
        do @(posedge i_clk); while (!o_in_ready);
        sent_cnt++;
    endtask

    // stop offering until every outstanding request has its result
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0)
            @(posedge i_clk);
    endtask

    // step size may only change with the block idle
    task automatic set_step(input logic [STEP_W-1:0] val);
        drain();
        cur_step    = val;
        i_cfg_valid <= 1'b1;
        i_step_size <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // one move: optional set, go mostly near the start point, a run of ticks with some noise, optional status
    task automatic run_move();
        logic signed [ANGLE_W-1:0] start_ang;
        logic [SPEED_W-1:0]        spd;
        int                        span;
        int                        tgt;
        int                        n_ticks;
        start_ang = ANGLE_W'($urandom);
        span      = (cur_step == '0) ? 8 : int'(cur_step) * 6 + 3;
        if ($urandom_range(0, 9) < 8)
            send_req(OP_SET, start_ang, SPEED_W'($urandom));
        if ($urandom_range(0, 9) == 0)
            tgt = int'(ANGLE_W'($urandom));
        else
            tgt = int'(start_ang) + int'($urandom_range(0, 2 * span)) - span;
        if (tgt > 32767)
            tgt = 32767;
        if (tgt < -32768)
            tgt = -32768;
        case ($urandom_range(0, 19))
            0:       spd = '0;
            1, 2, 3: spd = SPEED_W'($urandom_range(0, 65535));
            4, 5, 6: spd = SPEED_W'($urandom_range(50, 499));
            default: spd = SPEED_W'($urandom_range(500, 65535));
        endcase
        send_req(OP_GO, ANGLE_W'(tgt), spd);
        n_ticks = $urandom_range(2, 30);
        repeat (n_ticks) begin
            if ($urandom_range(0, 99) < 90)
                send_req(OP_TICK, ANGLE_W'($urandom), SPEED_W'($urandom));
            else
                send_req(OP_W'($urandom_range(0, 7)), ANGLE_W'($urandom), SPEED_W'($urandom));
        end
        if ($urandom_range(0, 9) < 7)
            send_req(OP_STATUS, ANGLE_W'($urandom), SPEED_W'($urandom));
    endtask

    task automatic run_moves(input int count);
        int stop_at;
        stop_at = sent_cnt + count;
        while (sent_cnt < stop_at)
            run_move();
    endtask

    // stimulus
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // straight after reset: stopped timer, status and unused codes
        send_req(OP_TICK, 16'sh8000, 16'hFFFF);
        send_req(OP_STATUS, 16'sh7FFF, 16'h0000);
        for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++)
            send_req(OP_W'(c), ANGLE_W'($urandom), SPEED_W'($urandom));
        // zero speed gives the full one second interval, then stop
        send_req(OP_GO, 16'sd1, 16'd0);
        send_req(OP_STOP, 16'sd0, 16'd0);
        // speed above the tick rate saturates to a one tick interval
        send_req(OP_GO, 16'sd2, 16'hFFFF);
        repeat (3)
            send_req(OP_TICK, 16'sd0, 16'd0);
        repeat (2)
            send_req(OP_STATUS, 16'sd0, 16'd0);
        send_req(OP_SET, 16'sh8000, 16'd0);

        // full-scale distance with the largest step
        set_step(8'd255);
        send_req(OP_SET, 16'sh8000, 16'd0);
        send_req(OP_GO, 16'sh7FFF, 16'd1000);
        repeat (2)
            send_req(OP_TICK, 16'sd0, 16'd0);
        // remaining distance below one step snaps to the target
        send_req(OP_SET, 16'sd32700, 16'd0);
        repeat (2)
            send_req(OP_TICK, 16'sd0, 16'd0);
        send_req(OP_GO, 16'sh8000, 16'd1001);
        send_req(OP_TICK, 16'sd0, 16'd0);

        // zero step: expiry re-drives the same angle until set onto the target
        set_step(8'd0);
        send_req(OP_SET, 16'sd5, 16'd0);
        send_req(OP_GO, 16'sd10, 16'd1000);
        send_req(OP_TICK, 16'sd0, 16'd0);
        send_req(OP_SET, 16'sd10, 16'd0);
        send_req(OP_TICK, 16'sd0, 16'd0);

        // unit step, sender mostly busy, receiver mostly stalling
        set_step(8'd1);
        send_idle = 15;
        recv_idle = 69;
        run_moves(400);

        // largest step, roles swapped, with a full pause half way
        set_step(8'd255);
        send_idle = 69;
        recv_idle = 15;
        run_moves(200);
        drain();
        run_moves(200);

        // random steps at full rate, first under a long output hold
        set_step(STEP_W'($urandom_range(2, 254)));
        send_idle = 0;
        recv_idle = 0;
        long_hold <= 1'b1;
        run_moves(220);
        drain();
        long_hold <= 1'b0;
        set_step(STEP_W'($urandom_range(2, 254)));
        run_moves(200);

        drain();
        repeat (20) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked, %0d reached events",
                 sent_cnt, result_cnt, reached_cnt);
        $display("step sizes 0, 1, 255 and random; both sides idling, plus a long output hold");
        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/sar_pkg.sv
rtl/sar_ctrl.sv
rtl/sar_dp.sv
rtl/servo_angle_ramp_core.sv
bench/servo_angle_ramp_checker.sv
bench/servo_angle_ramp_core_tb.sv
